// ----- hw/rtl/sle_pkg.sv -----
// ----------------------------------------------------------------------------
// sle_pkg
// Shared types, codes and field conversions for the sorted list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY    = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int FIELD_W     = 32;
    localparam int CNT_FIELD_W = 5;

    typedef logic signed [VALUE_WIDTH-1:0] t_val;
    typedef logic [COUNT_W-1:0]            t_count;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_POP    = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_PEEK   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_EXEC   = 2'd1,
        S_REPORT = 2'd2
    } t_state;

    // operation broadcast to every cell in the same cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_INSERT = 3'd1,
        CELL_REMOVE = 3'd2,
        CELL_DROP   = 3'd3,
        CELL_CLEAR  = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_val     value;
        logic     hit;
    } t_cell_ctl;

    // low VALUE_WIDTH bits of a 32-bit field
    function automatic t_val from_field(input logic [FIELD_W-1:0] f);
        t_val v;
        v = '0;
        for (int b = 0; b < VALUE_WIDTH; b++) begin
            if (b < FIELD_W) begin
                v[b] = f[b];
            end
        end
        return v;
    endfunction

    // raw value pattern, zero filled or cut to the 32-bit field
    function automatic logic [FIELD_W-1:0] to_field(input t_val v);
        logic [FIELD_W-1:0] f;
        f = '0;
        for (int b = 0; b < FIELD_W; b++) begin
            if (b < VALUE_WIDTH) begin
                f[b] = v[b];
            end
        end
        return f;
    endfunction

    function automatic logic [CNT_FIELD_W-1:0] to_cnt_field(input t_count c);
        logic [CNT_FIELD_W-1:0] f;
        f = '0;
        for (int b = 0; b < CNT_FIELD_W; b++) begin
            if (b < COUNT_W) begin
                f[b] = c[b];
            end
        end
        return f;
    endfunction

endpackage

// ----- hw/rtl/sle_cell.sv -----
// ----------------------------------------------------------------------------
// sle_cell
// One slot of the sorted row: holds a value and a valid bit, compares with
// the broadcast value and takes its neighbour's word when the row shifts.
// ----------------------------------------------------------------------------
module sle_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sle_pkg::t_cell_ctl i_ctl,
    input  sle_pkg::t_val     i_prev_val,
    input  logic              i_prev_valid,
    input  logic              i_prev_lt,
    input  sle_pkg::t_val     i_next_val,
    input  logic              i_next_valid,
    output sle_pkg::t_val     o_val,
    output logic              o_valid,
    output logic              o_lt,
    output logic              o_eq
);
    import sle_pkg::*;

    t_val r_val;
    logic r_valid;
    t_val n_val;
    logic n_valid;
    logic lt;
    logic ge;

    assign lt = r_valid && (r_val < i_ctl.value);
    assign ge = r_valid && !lt;

    always_comb begin
        n_val   = r_val;
        n_valid = r_valid;
        unique case (i_ctl.op)
            CELL_INSERT: begin
                if (!lt) begin
                    n_val   = i_prev_lt ? i_ctl.value : i_prev_val;
                    n_valid = r_valid || i_prev_valid;
                end
            end
            CELL_REMOVE: begin
                if (ge && i_ctl.hit) begin
                    n_val   = i_next_val;
                    n_valid = i_next_valid;
                end
            end
            CELL_DROP:  n_valid = r_valid && i_next_valid;
            CELL_CLEAR: n_valid = 1'b0;
            default:    ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload: no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val   = r_val;
    assign o_valid = r_valid;
    assign o_lt    = lt;
    assign o_eq    = r_valid && (r_val == i_ctl.value);

endmodule

// ----- hw/rtl/sorted_list_engine.sv -----
// Timing: a command is taken at the edge where start is high and busy low;
// it passes through the execute state, and its result is strobed from the
// report state; remove-all repeats the execute state once per match removed.
// Commands do not overlap: a new one is taken only after the take, execute
// and report states; remove-all compacts the cell row by one entry per cycle.
// Reset: synchronous, active low; the store reads empty afterwards.
// ----------------------------------------------------------------------------
// sorted_list_engine
// Ascending store of signed words in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module sorted_list_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_value,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count,
    output logic [31:0] o_smallest,
    output logic [31:0] o_largest,
    output logic [4:0]  o_removed_count,
    output logic [31:0] o_popped_value
);
    import sle_pkg::*;

    // --- command capture and control state ---
    t_state  r_state, n_state;
    t_cmd    r_cmd;
    t_val    r_value;
    t_count  r_count, n_count;
    t_count  r_removed, n_removed;
    t_status r_status, n_status;
    t_val    r_popped, n_popped;

    // --- cell row ---
    t_cell_ctl ctl;
    t_val      cell_val   [CAPACITY];
    logic      cell_valid [CAPACITY];
    logic      cell_lt    [CAPACITY];
    logic      cell_eq    [CAPACITY];
    logic      hit;
    t_val      last_val;
    logic      full;
    logic      empty;

    assign full  = (r_count == t_count'(CAPACITY));
    assign empty = (r_count == '0);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_val prev_val;
        logic prev_valid;
        logic prev_lt;
        t_val next_val;
        logic next_valid;

        if (g == 0) begin : g_first
            // on insert the front cell takes the new word whenever it does not stay
            assign prev_val   = r_value;
            assign prev_valid = 1'b1;
            assign prev_lt    = 1'b1;
        end else begin : g_mid
            assign prev_val   = cell_val[g-1];
            assign prev_valid = cell_valid[g-1];
            assign prev_lt    = cell_lt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            // nothing beyond the back cell: shifting in leaves it empty
            assign next_val   = r_value;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_val   = cell_val[g+1];
            assign next_valid = cell_valid[g+1];
        end

        sle_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_prev_val  (prev_val),
            .i_prev_valid(prev_valid),
            .i_prev_lt   (prev_lt),
            .i_next_val  (next_val),
            .i_next_valid(next_valid),
            .o_val       (cell_val[g]),
            .o_valid     (cell_valid[g]),
            .o_lt        (cell_lt[g]),
            .o_eq        (cell_eq[g])
        );
    end

    // any cell matching, and the back entry (valid cell with no valid
    // successor); both are flat reductions over independent cells
    always_comb begin
        hit      = 1'b0;
        last_val = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            hit = hit | cell_eq[k];
            if (k == CAPACITY - 1) begin
                last_val = last_val | (cell_valid[k] ? cell_val[k] : '0);
            end else begin
                last_val = last_val |
                           ((cell_valid[k] && !cell_valid[k+1]) ? cell_val[k] : '0);
            end
        end
    end

    // --- next state ---
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // remove-all keeps stepping while a match remains
                if (!(r_cmd == CMD_REMOVE && !empty && hit)) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // --- control outputs ---
    always_comb begin
        busy      = 1'b1;
        o_strobe  = 1'b0;
        ctl.op    = CELL_HOLD;
        ctl.value = r_value;
        ctl.hit   = hit;
        unique case (r_state)
            S_IDLE: busy = 1'b0;
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_INSERT: ctl.op = full ? CELL_HOLD : CELL_INSERT;
                    CMD_REMOVE: ctl.op = empty ? CELL_HOLD : CELL_REMOVE;
                    CMD_POP:    ctl.op = empty ? CELL_HOLD : CELL_DROP;
                    CMD_CLEAR:  ctl.op = CELL_CLEAR;
                    default:    ctl.op = CELL_HOLD;
                endcase
            end
            S_REPORT: o_strobe = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

    // --- count, status and result words ---
    always_comb begin
        n_count   = r_count;
        n_removed = r_removed;
        n_status  = r_status;
        n_popped  = r_popped;
        unique case (r_state)
            S_IDLE: begin
                // fresh result words for the next command
                n_removed = '0;
                n_popped  = '0;
                n_status  = ST_OK;
            end
            S_EXEC: begin
                unique case (r_cmd)
                    CMD_INSERT: begin
                        if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            n_count = r_count + t_count'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        priority if (empty) begin
                            // a run that emptied the row still removed something
                            n_status = (r_removed == '0) ? ST_EMPTY : ST_OK;
                        end else if (hit) begin
                            n_count   = r_count - t_count'(1);
                            n_removed = r_removed + t_count'(1);
                        end else begin
                            n_status = (r_removed == '0) ? ST_NOTFOUND : ST_OK;
                        end
                    end
                    CMD_POP: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_count  = r_count - t_count'(1);
                            n_popped = last_val;
                        end
                    end
                    CMD_CLEAR: n_count = '0;
                    default:   n_status = empty ? ST_EMPTY : ST_OK;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // capture the command word on acceptance; hold it through the run
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_cmd   <= t_cmd'(i_cmd);
            r_value <= from_field(i_value);
        end
        r_removed <= n_removed;
        r_status  <= n_status;
        r_popped  <= n_popped;
    end

    // result words; smallest and largest read straight from the row
    assign o_status        = r_status;
    assign o_count         = to_cnt_field(r_count);
    assign o_smallest      = cell_valid[0] ? to_field(cell_val[0]) : '0;
    assign o_largest       = empty ? '0 : to_field(last_val);
    assign o_removed_count = to_cnt_field(r_removed);
    assign o_popped_value  = to_field(r_popped);

endmodule

// ----- hw/rtl/sle_checker.sv -----
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the sorted list engine, bound to the top level.
// ----------------------------------------------------------------------------
module sle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [1:0]  o_status,
    input logic [4:0]  o_count,
    input logic [31:0] o_smallest,
    input logic [31:0] o_largest
);
    import sle_pkg::*;

    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result word strobed while idle");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_strobe))
        else $error("command word not held busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result word strobed twice");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_count == '0) |-> (o_smallest == '0 && o_largest == '0))
        else $error("empty store reports entries");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_count == 5'(CAPACITY)))
        else $error("full status with spare room");

endmodule

bind sorted_list_engine sle_checker u_sle_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .o_strobe  (o_strobe),
    .o_status  (o_status),
    .o_count   (o_count),
    .o_smallest(o_smallest),
    .o_largest (o_largest)
);

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sorted list engine. A local model of the
// ascending store predicts every result word; each strobed result is checked
// field by field against the oldest prediction. Directed words hit the empty,
// ordering and capacity cases, then random phases with varied sender idling
// drive the store through fill, drain and remove-all traffic.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sle_pkg::*;

    // command codes the block treats as peek
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    // settle allowance for the slowest remove-all, with margin
    localparam int         SETTLE_CYCLES   = 2 + CAPACITY + 8;
    localparam int         MAX_REPORTS     = 100;
    localparam int         POOL_SIZE       = 6;

    // one predicted result word
    typedef struct packed {
        t_status     status;
        logic [4:0]  count;
        logic [31:0] smallest;
        logic [31:0] largest;
        logic [4:0]  removed;
        logic [31:0] popped;
    } t_outcome;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd   = CMD_PEEK;
    logic [31:0] i_value = '0;
    logic        o_strobe;
    logic [1:0]  o_status;
    logic [4:0]  o_count;
    logic [31:0] o_smallest;
    logic [31:0] o_largest;
    logic [4:0]  o_removed_count;
    logic [31:0] o_popped_value;

    // model of the store: only the first list_size entries are meaningful
    t_val        list_entries [CAPACITY];
    int          list_size = 0;
    t_outcome    awaited_results [$];
    logic [31:0] value_pool [POOL_SIZE];

    int          sender_idle_pct = 0;
    int          n_errors        = 0;
    int          n_words         = 0;
    int          cmd_seen [8]    = '{default: 0};
    int          status_seen [4] = '{default: 0};
    int          most_removed    = 0;

    sorted_list_engine dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_status        (o_status),
        .o_count         (o_count),
        .o_smallest      (o_smallest),
        .o_largest       (o_largest),
        .o_removed_count (o_removed_count),
        .o_popped_value  (o_popped_value)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Store model: apply one command and return the result word it causes.
    // ------------------------------------------------------------------------
    function automatic t_outcome next_list_result(input logic [2:0] cmd, input t_val v);
        t_outcome r;
        int       pos;
        int       kept;
        r        = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (list_size >= CAPACITY) begin
                    // full: drop the word, leave the store alone
                    r.status = ST_FULL;
                end else begin
                    // equal values go ahead of their twins, which nobody can see
                    pos = 0;
                    while (pos < list_size && list_entries[pos] < v) pos++;
                    for (int i = list_size; i > pos; i--) begin
                        list_entries[i] = list_entries[i-1];
                    end
                    list_entries[pos] = v;
                    list_size++;
                end
            end
            CMD_REMOVE: begin
                if (list_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // compact the survivors towards the front
                    kept = 0;
                    for (int i = 0; i < list_size; i++) begin
                        if (list_entries[i] != v) begin
                            list_entries[kept] = list_entries[i];
                            kept++;
                        end
                    end
                    r.removed = 5'(list_size - kept);
                    if (kept == list_size) begin
                        r.status = ST_NOTFOUND;
                    end
                    list_size = kept;
                end
            end
            CMD_POP: begin
                if (list_size == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    list_size--;
                    r.popped = list_entries[list_size];
                end
            end
            CMD_CLEAR: begin
                list_size = 0;
            end
            default: begin
                // peek, and the spare codes behave the same
                if (list_size == 0) begin
                    r.status = ST_EMPTY;
                end
            end
        endcase
        if (list_size > 0) begin
            r.smallest = list_entries[0];
            r.largest  = list_entries[list_size-1];
        end
        r.count = 5'(list_size);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker: every strobed word must match the oldest prediction.
    // The receiver cannot hold results off, so sample on every edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_outcome want;
        if (i_rst_n && o_strobe) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result word strobed with none awaited");
            end else begin
                want = awaited_results.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                end
                if (o_count !== want.count) begin
                    report_mismatch($sformatf("count got %0d want %0d",
                                              o_count, want.count));
                end
                if (o_smallest !== want.smallest) begin
                    report_mismatch($sformatf("smallest got %h want %h",
                                              o_smallest, want.smallest));
                end
                if (o_largest !== want.largest) begin
                    report_mismatch($sformatf("largest got %h want %h",
                                              o_largest, want.largest));
                end
                if (o_removed_count !== want.removed) begin
                    report_mismatch($sformatf("removed_count got %0d want %0d",
                                              o_removed_count, want.removed));
                end
                if (o_popped_value !== want.popped) begin
                    report_mismatch($sformatf("popped_value got %h want %h",
                                              o_popped_value, want.popped));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Send one command word. Idle first at the current sender rate, then hold
    // start high until an edge finds busy low; that edge takes the word.
    // Start is left high on return so back-to-back words keep it asserted.
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] value);
        t_outcome r;
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_value <= value;
        do @(posedge i_clk); while (busy !== 1'b0);
        r = next_list_result(cmd, value);
        awaited_results.push_back(r);
        n_words++;
        cmd_seen[cmd]++;
        status_seen[r.status]++;
        if (int'(r.removed) > most_removed) most_removed = r.removed;
    endtask

    // Drop start and hold off until every awaited word has come back.
    // Always advance at least one edge so start is never lowered and
    // raised in the same step.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (awaited_results.size() != 0);
    endtask

    // Value for a word: often one already stored (so removes hit), else a
    // value from the small pool (so duplicates build up), an extreme, or
    // anything at all.
    function automatic logic [31:0] pick_value(input bit prefer_stored);
        int roll;
        roll = $urandom_range(99);
        if (prefer_stored && list_size > 0 && roll < 60) begin
            return list_entries[$urandom_range(list_size - 1)];
        end
        if (roll < 75) begin
            return value_pool[$urandom_range(POOL_SIZE - 1)];
        end
        if (roll < 85) begin
            case ($urandom_range(3))
                0:       return 32'h8000_0000;
                1:       return 32'h7fff_ffff;
                2:       return 32'h0000_0000;
                default: return 32'hffff_ffff;
            endcase
        end
        return $urandom();
    endfunction

    // ------------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------------

    // Commands on an empty store: peek, pop, remove and a spare code all report empty.
    task automatic test_empty_store();
        send_word(CMD_PEEK, 32'h0000_0000);
        send_word(CMD_POP, 32'h1234_5678);
        send_word(CMD_REMOVE, 32'h0000_0000);
        send_word(CMD_SPARE_FIRST, 32'hffff_ffff);
    endtask

    // Signed ordering at the extremes, duplicates, miss and hit on remove.
    task automatic test_ordering();
        send_word(CMD_INSERT, 32'h0000_0000);
        send_word(CMD_INSERT, 32'h7fff_ffff);
        send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'hffff_ffff);
        send_word(CMD_INSERT, 32'hffff_ffff);
        send_word(CMD_REMOVE, 32'h0000_0005);
        send_word(CMD_REMOVE, 32'hffff_ffff);
        send_word(CMD_SPARE_LAST, 32'h0000_0000);
        send_word(CMD_POP, 32'h0000_0000);
        send_word(CMD_POP, 32'h0000_0000);
    endtask

    // Fill with the most negative value, overflow once, then remove every
    // entry in one go and check clear on a non-empty store.
    task automatic test_capacity();
        while (list_size < CAPACITY) send_word(CMD_INSERT, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h0000_0001);
        send_word(CMD_REMOVE, 32'h8000_0000);
        send_word(CMD_INSERT, 32'h0000_0001);
        send_word(CMD_CLEAR, 32'h0000_0000);
    endtask

    // Random traffic. The insert share swings every forty words so the
    // store fills up, hits the ceiling and drains again.
    task automatic test_random(input int n_items, input int idle_pct);
        logic [2:0] cmd;
        int         grow;
        int         roll;
        sender_idle_pct = idle_pct;
        grow            = 50;
        for (int p = 0; p < POOL_SIZE; p++) begin
            if (p < 2) value_pool[p] = $urandom();
            else       value_pool[p] = 32'($signed($urandom_range(8)) - 4);
        end
        for (int k = 0; k < n_items; k++) begin
            if (k % 40 == 0) grow = $urandom_range(25, 80);
            roll = $urandom_range(99);
            if (roll < grow) begin
                cmd = CMD_INSERT;
            end else begin
                roll = $urandom_range(99);
                if      (roll < 45) cmd = CMD_REMOVE;
                else if (roll < 75) cmd = CMD_POP;
                else if (roll < 87) cmd = CMD_PEEK;
                else if (roll < 94) cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
                else                cmd = CMD_CLEAR;
            end
            send_word(cmd, pick_value(cmd == CMD_REMOVE));
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_store();
        test_ordering();
        test_capacity();
        // hold the sender until the directed words have all come back
        wait_for_results();

        test_random(400, 0);
        wait_for_results();
        test_random(400, 59);
        wait_for_results();
        test_random(400, 26);
        test_random(400, 0);

        // drain, then let the slowest possible remove finish
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (awaited_results.size() != 0) begin
            report_mismatch($sformatf("%0d result words never arrived",
                                      awaited_results.size()));
        end

        $display("Covered %0d words: %0d insert, %0d remove, %0d pop, %0d clear, %0d peek, %0d spare",
                 n_words, cmd_seen[CMD_INSERT], cmd_seen[CMD_REMOVE], cmd_seen[CMD_POP],
                 cmd_seen[CMD_CLEAR], cmd_seen[CMD_PEEK],
                 cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
        $display("Outcomes: %0d ok, %0d full, %0d empty, %0d not found; most removed at once %0d",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
                 status_seen[ST_NOTFOUND], most_removed);
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sorted_list_engine.sv
hw/rtl/sle_checker.sv
test/testbench.sv
